/* design/hmbd_pkg.sv */
// shared types and constants for the handheld memory bus decoder
package hmbd_pkg;

	// backing byte store
	localparam int STORE_DEPTH = 524288;
	localparam int SA_W        = $clog2(STORE_DEPTH);
	localparam int IDX_W       = 19;

	// decoupling queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		REQ_READ  = 2'd0,
		REQ_WRITE = 2'd1,
		REQ_LOAD  = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		MC_MONO  = 2'd0,
		MC_EARLY = 2'd1,
		MC_LATE  = 2'd2,
		MC_NONE  = 2'd3
	} model_t;

	// work handed from the front to the back
	typedef enum logic [1:0] {
		OP_CONST = 2'd0,
		OP_READ  = 2'd1,
		OP_WRITE = 2'd2
	} op_t;

	typedef struct packed {
		op_t             op;
		logic [SA_W-1:0] addr;
		logic [7:0]      data;
	} q_entry_t;

endpackage

/* design/hmbd_ram.sv */
// generic single port ram with registered read
module hmbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

/* design/hmbd_front.sv */
// front end: accepts bus transactions, decodes the map, keeps bank and dma latch
module hmbd_front import hmbd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	input  logic [1:0]       cfg_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       req_type,
	input  logic [15:0]      bus_address,
	input  logic [18:0]      store_index,
	input  logic [7:0]       write_data,
	input  logic             obj_mem_locked,
	input  logic             q_full,
	input  logic             clr_busy,
	output logic             q_push,
	output q_entry_t         q_wentry
);

	localparam logic [15:0] BANK_LO  = 16'h2000;
	localparam logic [15:0] BANK_HI  = 16'h3FFF;
	localparam logic [15:0] WIN_LO   = 16'h4000;
	localparam logic [15:0] WIN_HI   = 16'h7FFF;
	localparam logic [15:0] ECHO_LO  = 16'hE000;
	localparam logic [15:0] ECHO_HI  = 16'hFDFF;
	localparam logic [15:0] ECHO_OFS = 16'h2000;
	localparam logic [15:0] UNUS_LO  = 16'hFEA0;
	localparam logic [15:0] UNUS_HI  = 16'hFEFF;
	localparam logic [15:0] DMA_ADDR = 16'hFF46;

	logic [4:0]       bank_q;
	logic [7:0]       dma_q;
	model_t           model_q;
	logic [IDX_W-1:0] idx;
	logic             store_acc;
	logic             store_rd;
	logic             in_range;
	logic             bank_we;
	logic             dma_we;
	logic [7:0]       unus_val;
	logic             accept;
	logic             in_win, in_echo, in_unus, is_dma, in_bank;

	assign in_ready = !q_full && !clr_busy;
	assign accept   = in_valid && in_ready;
	assign q_push   = accept;

	assign in_win  = (bus_address >= WIN_LO) && (bus_address <= WIN_HI);
	assign in_echo = (bus_address >= ECHO_LO) && (bus_address <= ECHO_HI);
	assign in_unus = (bus_address >= UNUS_LO) && (bus_address <= UNUS_HI);
	assign is_dma  = (bus_address == DMA_ADDR);
	assign in_bank = (bus_address >= BANK_LO) && (bus_address <= BANK_HI);

	always_comb begin
		if (obj_mem_locked) begin
			unus_val = 8'hFF;
		end else begin
			case (model_q)
				MC_MONO:  unus_val = 8'h00;
				MC_EARLY: unus_val = {2'b00, bus_address[5:0]};
				MC_LATE:  unus_val = {bus_address[7:4], bus_address[7:4]};
				default:  unus_val = 8'hFF;
			endcase
		end
	end

	always_comb begin
		idx       = '0;
		store_acc = 1'b0;
		store_rd  = 1'b0;
		bank_we   = 1'b0;
		dma_we    = 1'b0;
		q_wentry  = '{op: OP_CONST, addr: '0, data: 8'h00};
		case (req_t'(req_type))
			REQ_READ: begin
				if (in_win) begin
					idx       = {bank_q, bus_address[13:0]};
					store_acc = 1'b1;
					store_rd  = 1'b1;
				end else if (in_echo) begin
					idx       = IDX_W'(bus_address - ECHO_OFS);
					store_acc = 1'b1;
					store_rd  = 1'b1;
				end else if (in_unus) begin
					q_wentry.data = unus_val;
				end else if (is_dma) begin
					q_wentry.data = dma_q;
				end else begin
					idx       = IDX_W'(bus_address);
					store_acc = 1'b1;
					store_rd  = 1'b1;
				end
			end
			REQ_WRITE: begin
				if (in_bank) begin
					bank_we = 1'b1;
				end else if (bus_address <= WIN_HI) begin
					// rom area writes are dropped
				end else if (in_echo) begin
					idx       = IDX_W'(bus_address - ECHO_OFS);
					store_acc = 1'b1;
				end else if (in_unus) begin
					// unusable area writes are dropped
				end else if (is_dma) begin
					dma_we = 1'b1;
				end else begin
					idx       = IDX_W'(bus_address);
					store_acc = 1'b1;
				end
			end
			REQ_LOAD: begin
				idx       = store_index;
				store_acc = 1'b1;
			end
			default: begin
			end
		endcase

		in_range = 32'(idx) < 32'(STORE_DEPTH);
		if (store_acc) begin
			if (in_range) begin
				q_wentry.op   = store_rd ? OP_READ : OP_WRITE;
				q_wentry.addr = SA_W'(idx);
				q_wentry.data = write_data;
			end else begin
				q_wentry.data = store_rd ? 8'hFF : 8'h00;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q  <= 5'd1;
			dma_q   <= 8'h00;
			model_q <= MC_MONO;
		end else begin
			if (cfg_valid) begin
				model_q <= model_t'(cfg_data);
			end
			if (accept && bank_we) begin
				bank_q <= write_data[4:0];
			end
			if (accept && dma_we) begin
				dma_q <= write_data;
			end
		end
	end

endmodule

/* design/hmbd_queue.sv */
// short fifo of decoded work between front and back
module hmbd_queue import hmbd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t wentry,
	input  logic     pop,
	output q_entry_t rentry,
	output logic     full,
	output logic     empty
);

	q_entry_t            slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wptr_q;
	logic [QPTR_W-1:0]   rptr_q;
	logic [QCNT_W-1:0]   cnt_q;

	localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);

	assign full   = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign empty  = (cnt_q == '0);
	assign rentry = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= wentry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PTR_LAST) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PTR_LAST) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* design/hmbd_back.sv */
// back end: clears the store after reset, carries out store accesses, holds the result
module hmbd_back import hmbd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  q_entry_t   q_rentry,
	output logic       q_pop,
	output logic       clr_busy,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] read_data
);

	localparam logic [SA_W-1:0] CLR_LAST = SA_W'(STORE_DEPTH - 1);

	logic            clr_busy_q;
	logic [SA_W-1:0] clr_idx_q;
	logic            valid_s1;
	logic            sel_ram_s1;
	logic [7:0]      const_s1;
	logic            issue;
	logic            ram_we;
	logic            ram_re;
	logic [SA_W-1:0] ram_addr;
	logic [7:0]      ram_wdata;
	logic [7:0]      ram_rdata;

	assign clr_busy = clr_busy_q;
	assign issue    = !clr_busy_q && !q_empty && (!valid_s1 || out_ready);
	assign q_pop    = issue;

	always_comb begin
		if (clr_busy_q) begin
			ram_addr  = clr_idx_q;
			ram_we    = 1'b1;
			ram_re    = 1'b0;
			ram_wdata = 8'h00;
		end else begin
			ram_addr  = q_rentry.addr;
			ram_we    = issue && (q_rentry.op == OP_WRITE);
			ram_re    = issue && (q_rentry.op == OP_READ);
			ram_wdata = q_rentry.data;
		end
	end

	hmbd_ram #(
		.WIDTH (8),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
			valid_s1   <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == CLR_LAST) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (out_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			sel_ram_s1 <= (q_rentry.op == OP_READ);
			const_s1   <= (q_rentry.op == OP_CONST) ? q_rentry.data : 8'h00;
		end
	end

	assign out_valid = valid_s1;
	assign read_data = sel_ram_s1 ? ram_rdata : const_s1;

endmodule

/* design/handheld_memory_bus_decoder.sv */
// top level of the handheld memory bus decoder: front, queue and back
// path: an accepted transaction is written into the queue, then issued into the result stage
// throughput: one transaction per cycle while out_ready is high, set by the single store port in the back
// reset: bank 1, dma latch 0, model class 0; the store is then cleared one byte a cycle,
// all STORE_DEPTH (524288) bytes, with in_ready low; configuration writes are taken throughout
module handheld_memory_bus_decoder import hmbd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: model class
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_data,
	// request channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [15:0] bus_address,
	input  logic [18:0] store_index,
	input  logic [7:0]  write_data,
	input  logic        obj_mem_locked,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  read_data
);

	// decoded work travelling front to back
	q_entry_t q_wentry;
	q_entry_t q_rentry;
	logic     q_push;
	logic     q_pop;
	logic     q_full;
	logic     q_empty;
	logic     clr_busy;

	// cfg_ready is tied high, so a model class write is always accepted
	assign cfg_ready = 1'b1;

	// front: decode the bus map, resolve bank, dma latch and unusable area right away
	hmbd_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.req_type       (req_type),
		.bus_address    (bus_address),
		.store_index    (store_index),
		.write_data     (write_data),
		.obj_mem_locked (obj_mem_locked),
		.q_full         (q_full),
		.clr_busy       (clr_busy),
		.q_push         (q_push),
		.q_wentry       (q_wentry)
	);

	// queue lets the front keep accepting while the output stalls, until its two entries are full
	hmbd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wentry (q_wentry),
		.pop    (q_pop),
		.rentry (q_rentry),
		.full   (q_full),
		.empty  (q_empty)
	);

	// back: store reads and writes in order, result held until taken
	hmbd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_rentry  (q_rentry),
		.q_pop     (q_pop),
		.clr_busy  (clr_busy),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.read_data (read_data)
	);

	// no transaction may slip in while the store is being cleared
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !in_ready)
		else $error("request accepted during store clear");

	// the back only takes work that exists
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("queue popped while empty");

	// the front never overruns the queue
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue pushed while full");

endmodule

/* bench/tb_handheld_memory_bus_decoder.sv */
`timescale 1ns / 1ps
// self-checking testbench for the handheld memory bus decoder: bus map, bank select, loads
module tb_handheld_memory_bus_decoder;
	import hmbd_pkg::*;

	localparam int CLK_HALF      = 5;
	localparam int RANDOM_ITEMS  = 1600;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int SETTLE_CYCLES = 4;
	localparam int REPORT_LINES  = 40;
	// clearing pass plus traffic, with plenty of headroom
	localparam longint TIMEOUT_NS = 64'd40_000_000;

	// bus map boundaries
	localparam logic [15:0] BANK_SEL_LO = 16'h2000;
	localparam logic [15:0] WINDOW_LO   = 16'h4000;
	localparam logic [15:0] WINDOW_HI   = 16'h7FFF;
	localparam logic [15:0] ECHO_LO     = 16'hE000;
	localparam logic [15:0] ECHO_HI     = 16'hFDFF;
	localparam logic [15:0] ECHO_SHIFT  = 16'h2000;
	localparam logic [15:0] GAP_LO      = 16'hFEA0;
	localparam logic [15:0] GAP_HI      = 16'hFEFF;
	localparam logic [15:0] DMA_ADDR    = 16'hFF46;
	localparam logic [7:0]  BANK_MASK   = 8'h1F;

	// one bus transaction as the request channel carries it
	typedef struct {
		req_t        kind;
		logic [15:0] addr;
		logic [18:0] idx;
		logic [7:0]  data;
		logic        blocked;
	} bus_access_t;

	// predicted read byte and the clock count at which its request was taken
	typedef struct {
		logic [7:0]  value;
		int unsigned taken_at;
	} read_byte_t;

	logic        clk;
	logic        arst_n         = 1'b0;
	logic        cfg_valid      = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_data       = MC_MONO;
	logic        in_valid       = 1'b0;
	logic        in_ready;
	logic [1:0]  req_type       = REQ_READ;
	logic [15:0] bus_address    = '0;
	logic [18:0] store_index    = '0;
	logic [7:0]  write_data     = '0;
	logic        obj_mem_locked = 1'b0;
	logic        out_valid;
	logic        out_ready      = 1'b0;
	logic [7:0]  read_data;

	// shadow of the decoder state
	logic [7:0]  store_image [int unsigned];
	logic [4:0]  bank_sel    = 5'd1;
	logic [7:0]  dma_byte    = 8'h00;
	model_t      model_sel   = MC_MONO;

	read_byte_t  expected_bytes [$];
	read_byte_t  oldest;
	int unsigned clk_count   = 0;
	int          error_count = 0;
	int          burst_left  = 0;

	// receiver stall pattern, re-chosen every so often
	logic [15:0] ready_bits  = 16'hFFFF;
	int          ready_phase = 0;

	handheld_memory_bus_decoder i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.req_type       (req_type),
		.bus_address    (bus_address),
		.store_index    (store_index),
		.write_data     (write_data),
		.obj_mem_locked (obj_mem_locked),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.read_data      (read_data)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// free-running count, used to keep a result from matching a request taken at the same edge
	always @(posedge clk) clk_count <= clk_count + 1;

	task automatic report_mismatch(string msg);
		error_count++;
		if (error_count <= REPORT_LINES)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	// ---------------------------------------------------------------- predictor

	// byte store as seen by the bus, 0xFF past its end, zero where never written
	function automatic logic [7:0] store_byte(int unsigned idx);
		if (idx >= STORE_DEPTH)
			return 8'hFF;
		if (store_image.exists(idx))
			return store_image[idx];
		return 8'h00;
	endfunction

	// writes past the end of the store are dropped
	function automatic void store_set(int unsigned idx, logic [7:0] v);
		if (idx < STORE_DEPTH)
			store_image[idx] = v;
	endfunction

	// the unusable area answers by blocking and model class
	function automatic logic [7:0] unusable_byte(logic [15:0] a, logic blocked);
		if (blocked)
			return 8'hFF;
		case (model_sel)
			MC_MONO:  return 8'h00;
			MC_EARLY: return {2'b00, a[5:0]};
			MC_LATE:  return {a[7:4], a[7:4]};
			default:  return 8'hFF;
		endcase
	endfunction

	function automatic logic [7:0] bus_read_byte(logic [15:0] a, logic blocked);
		// switchable window: bank times 16 KiB plus the offset
		if (a >= WINDOW_LO && a <= WINDOW_HI)
			return store_byte((32'(bank_sel) << 14) + 32'(a - WINDOW_LO));
		if (a >= ECHO_LO && a <= ECHO_HI)
			return store_byte(32'(a - ECHO_SHIFT));
		if (a >= GAP_LO && a <= GAP_HI)
			return unusable_byte(a, blocked);
		if (a == DMA_ADDR)
			return dma_byte;
		return store_byte(32'(a));
	endfunction

	function automatic void bus_write_byte(logic [15:0] a, logic [7:0] v);
		if (a >= BANK_SEL_LO && a < WINDOW_LO)
			bank_sel = 5'(v & BANK_MASK);
		else if (a <= WINDOW_HI)
			; // rest of the rom space ignores writes
		else if (a >= ECHO_LO && a <= ECHO_HI)
			store_set(32'(a - ECHO_SHIFT), v);
		else if (a >= GAP_LO && a <= GAP_HI)
			; // unusable area ignores writes
		else if (a == DMA_ADDR)
			dma_byte = v;
		else
			store_set(32'(a), v);
	endfunction

	// advance the shadow state by one transaction and return the byte it must answer
	function automatic logic [7:0] predict_access(bus_access_t t);
		case (t.kind)
			REQ_READ:  return bus_read_byte(t.addr, t.blocked);
			REQ_WRITE: bus_write_byte(t.addr, t.data);
			REQ_LOAD:  store_set(32'(t.idx), t.data);
			default:   ; // unused request type leaves everything alone
		endcase
		return 8'h00;
	endfunction

	// ---------------------------------------------------------------- driving

	// one request transaction; bursts of random length separated by random gaps
	task automatic issue_access(bus_access_t t);
		int gap;
		logic [7:0] want;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left = burst_left - 1;
		in_valid       <= 1'b1;
		req_type       <= t.kind;
		bus_address    <= t.addr;
		store_index    <= t.idx;
		write_data     <= t.data;
		obj_mem_locked <= t.blocked;
		do @(posedge clk); while (in_ready !== 1'b1);
		want = predict_access(t);
		expected_bytes.push_back('{value: want, taken_at: clk_count});
	endtask

	// stop sending and let every outstanding result byte come back
	task automatic drain_results();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		burst_left = 0;
		while (expected_bytes.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (expected_bytes.size() != 0) begin
			report_mismatch($sformatf("%0d results never arrived", expected_bytes.size()));
			expected_bytes.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// model class write, only while the decoder is idle
	task automatic set_model_class(model_t m);
		cfg_valid <= 1'b1;
		cfg_data  <= m;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		model_sel = m;
	endtask

	function automatic bus_access_t bus_op(req_t kind, logic [15:0] addr, logic [18:0] idx,
			logic [7:0] data, logic blocked);
		bus_access_t t;
		t.kind    = kind;
		t.addr    = addr;
		t.idx     = idx;
		t.data    = data;
		t.blocked = blocked;
		return t;
	endfunction

	// offsets cluster at both ends of a bank so loads and window reads meet
	function automatic logic [13:0] hot_offset();
		logic [13:0] off;
		int r;
		off = 14'($urandom_range(0, 15));
		r = $urandom_range(0, 7);
		if (r < 4)
			return off;
		if (r < 6)
			return 14'h3FFF - off;
		return 14'($urandom);
	endfunction

	// a few small ram neighborhoods, some reached through the echo range
	function automatic logic [15:0] ram_address();
		logic [15:0] bases [8] = '{16'h8000, 16'h9FF0, 16'hC000, 16'hDDF0,
			16'hFE00, 16'hFE90, 16'hFF00, 16'hFFF0};
		logic [15:0] a;
		a = bases[$urandom_range(0, 7)] + 16'($urandom_range(0, 15));
		if (a >= 16'hC000 && a <= 16'hDDFF && $urandom_range(0, 1) == 1)
			a = a + ECHO_SHIFT;
		return a;
	endfunction

	// mostly well-aimed traffic with random content, the rest plain noise
	function automatic bus_access_t random_access();
		bus_access_t t;
		int pick;
		t.kind    = req_t'($urandom_range(0, 2));
		t.addr    = 16'($urandom);
		t.idx     = 19'($urandom);
		t.data    = 8'($urandom);
		t.blocked = 1'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			t.kind = REQ_LOAD;
			t.idx  = {5'($urandom_range(0, 31)), hot_offset()};
		end else if (pick < 25) begin
			t.kind = REQ_WRITE;
			t.addr = BANK_SEL_LO | 16'($urandom_range(0, 16'h1FFF));
		end else if (pick < 45) begin
			t.kind = REQ_READ;
			t.addr = WINDOW_LO | 16'(hot_offset());
		end else if (pick < 55) begin
			t.kind = REQ_WRITE;
			t.addr = ram_address();
		end else if (pick < 67) begin
			t.kind = REQ_READ;
			t.addr = ram_address();
		end else if (pick < 72) begin
			t.kind = ($urandom_range(0, 1) == 1) ? REQ_WRITE : REQ_READ;
			t.addr = DMA_ADDR;
		end else if (pick < 80) begin
			t.kind = REQ_READ;
			t.addr = GAP_LO + 16'($urandom_range(0, 95));
		end else if (pick < 88) begin
			t.kind = REQ_READ;
			t.addr = {2'b00, hot_offset()};
		end else begin
			t.kind = req_t'($urandom_range(0, 3));
		end
		return t;
	endfunction

	// ---------------------------------------------------------------- result side

	// stall pattern: sometimes always ready, sometimes random, sometimes sparse
	always @(posedge clk) begin
		if (ready_phase == 0) begin
			ready_phase <= $urandom_range(16, 96);
			case ($urandom_range(0, 3))
				0:       ready_bits <= 16'hFFFF;
				1:       ready_bits <= 16'($urandom) | 16'h0001;
				2:       ready_bits <= 16'h0101;
				default: ready_bits <= (16'($urandom) & 16'($urandom)) | 16'h0001;
			endcase
		end else begin
			ready_phase <= ready_phase - 1;
		end
		out_ready <= ready_bits[clk_count[3:0]];
	end

	// every result transaction must match the oldest prediction, in order
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (expected_bytes.size() == 0 || expected_bytes[0].taken_at == clk_count) begin
				report_mismatch($sformatf("unexpected result transaction, read_data %02h",
					read_data));
			end else begin
				oldest = expected_bytes.pop_front();
				if (read_data !== oldest.value)
					report_mismatch($sformatf("read_data %02h, predicted %02h",
						read_data, oldest.value));
			end
		end
	end

	// ---------------------------------------------------------------- tests

	// map edges, bank select incl. bank zero and the top bank, echo, dma latch
	task automatic test_directed_map();
		issue_access(bus_op(REQ_LOAD, 16'hFFFF, 19'd0, 8'hA5, 1'b1));
		issue_access(bus_op(REQ_LOAD, 16'h0000, 19'h7FFFF, 8'h5A, 1'b0));
		issue_access(bus_op(REQ_READ, 16'h0000, 19'h7FFFF, 8'hFF, 1'b1));
		// top bank, then the last byte of the window is the last byte of the store
		issue_access(bus_op(REQ_WRITE, BANK_SEL_LO, 19'd0, 8'hFF, 1'b0));
		issue_access(bus_op(REQ_READ, WINDOW_HI, 19'd0, 8'h00, 1'b0));
		// bank zero is kept as written, the window then mirrors the fixed bank
		issue_access(bus_op(REQ_WRITE, 16'h3FFF, 19'h7FFFF, 8'hE0, 1'b1));
		issue_access(bus_op(REQ_READ, WINDOW_LO, 19'd0, 8'h00, 1'b0));
		// echo read and echo write
		issue_access(bus_op(REQ_WRITE, 16'hC000, 19'd0, 8'h3C, 1'b0));
		issue_access(bus_op(REQ_READ, ECHO_LO, 19'd0, 8'h00, 1'b0));
		issue_access(bus_op(REQ_WRITE, ECHO_HI, 19'd0, 8'hC3, 1'b0));
		issue_access(bus_op(REQ_READ, 16'hDDFF, 19'd0, 8'h00, 1'b0));
		// dma latch lives apart from the store
		issue_access(bus_op(REQ_WRITE, DMA_ADDR, 19'd0, 8'h81, 1'b0));
		issue_access(bus_op(REQ_READ, DMA_ADDR, 19'd0, 8'h00, 1'b0));
		// ignored writes: low rom, window, unusable area
		issue_access(bus_op(REQ_WRITE, 16'h1000, 19'd0, 8'h77, 1'b0));
		issue_access(bus_op(REQ_WRITE, 16'h5000, 19'd0, 8'h77, 1'b0));
		issue_access(bus_op(REQ_WRITE, GAP_LO, 19'd0, 8'h77, 1'b0));
		issue_access(bus_op(REQ_READ, 16'h1000, 19'd0, 8'h00, 1'b0));
		// unused request type with every field at its top value
		issue_access(bus_op(REQ_NONE, 16'hFFFF, 19'h7FFFF, 8'hFF, 1'b1));
		issue_access(bus_op(REQ_READ, 16'hFFFF, 19'd0, 8'h00, 1'b0));
	endtask

	// unusable area under every model class, plus the blocked answer
	task automatic test_unusable_area();
		for (int i = 0; i < 4; i++) begin
			drain_results();
			set_model_class(model_t'(i));
			issue_access(bus_op(REQ_READ, 16'hFEA5, 19'd0, 8'h00, 1'b0));
			issue_access(bus_op(REQ_READ, GAP_HI, 19'd0, 8'h00, 1'b0));
		end
		issue_access(bus_op(REQ_READ, 16'hFEC3, 19'd0, 8'h00, 1'b1));
	endtask

	// random traffic in phases, one model class per phase
	task automatic test_random_traffic();
		model_t order [4] = '{MC_NONE, MC_LATE, MC_EARLY, MC_MONO};
		for (int p = 0; p < 4; p++) begin
			drain_results();
			set_model_class(order[p]);
			repeat (RANDOM_ITEMS / 4) issue_access(random_access());
		end
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		// the first transaction waits out the clearing pass on in_ready
		test_directed_map();
		test_unusable_area();
		test_random_traffic();
		drain_results();
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// watchdog
	initial begin
		#(TIMEOUT_NS);
		$display("FAIL");
		$finish;
	end

endmodule
